>>> rtl/mfsc_pkg.sv
// Shared types and constants for the median-filtered sensor calibration block.
// No dependencies; imported by the top level and its checker.
package mfsc_pkg;

    // Fixed field widths
    localparam int TEMP_W     = 16;  // temperature, Q8.8 signed
    localparam int GAIN_W     = 16;  // gain, Q8.8 signed
    localparam int OFFSET_W   = 20;  // offset, Q.8 signed
    localparam int CFG_W      = 20;  // widest register
    localparam int CFG_IDX_W  = 2;

    // Half counts (Q.1) to Q.8 counts
    localparam int MED_SHIFT  = 7;
    // Temperature scaling: quotient of (num * 2^FRAC_SHIFT) / gain
    localparam int FRAC_SHIFT = 8;
    // Quotient bits kept by the divider; one above the temperature range
    localparam int QUOT_W     = TEMP_W + 1;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7FFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 16'h8000;

    // Result flag positions in m_tuser
    localparam int SAT_BIT    = 0;
    localparam int ZG_BIT     = 1;
    localparam int OUT_USER_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_ON    = 2'd0,
        REG_OFFSET_ON  = 2'd1,
        REG_GAIN_OFF   = 2'd2,
        REG_OFFSET_OFF = 2'd3
    } cfg_reg_t;

endpackage

>>> rtl/mfsc_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module mfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rd_a_reg <= mem_array[raddr_a];
        rd_b_reg <= mem_array[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> rtl/median_filtered_sensor_calibration.sv
// Median-filtered linear sensor calibration, top level.
// Depends on mfsc_pkg and mfsc_ram.
//
//  Channel   Direction  Signals                          Content
//  -------   ---------  -------------------------------  ----------------------------------
//  cfg       in         cfg_wen, cfg_index, cfg_data     gain/offset register writes
//  s         in         s_tvalid/tready/tdata/tuser      adc_sample, pump_on
//  m         out        m_tvalid/tready/tdata/tuser      temperature, median, flags
//
//  One item at a time. After the input transfer the block sweeps the window with a
//  single subtractor: WINDOW*WINDOW compares to rank every entry, then one quotient
//  bit per cycle for all QUOT_W bits. The divide is skipped when the gain is zero or
//  the quotient overflows.
//  Reset: per-entry valid bits make unwritten window entries read as zero; no clearing.
//  Stalls: the result sits in an output register, and a new input transfer is taken
//  while it waits; a finished item holds only if that register is still full.
module median_filtered_sensor_calibration #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration writes
    input  logic                                  cfg_wen,
    input  logic [mfsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mfsc_pkg::CFG_W-1:0]            cfg_data,
    // Sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // adc_sample
    input  logic                                  s_tuser,   // pump_on
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((mfsc_pkg::TEMP_W+SAMPLE_BITS+8)/8)*8-1:0] m_tdata,
                                                  // temperature, median_half_counts
    output logic [mfsc_pkg::OUT_USER_W-1:0]       m_tuser    // saturated, zero_gain
);

    import mfsc_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int MED_W   = SAMPLE_BITS + 1;
    localparam int OUT_W   = ((TEMP_W + MED_W + 7) / 8) * 8;
    // Signed width of 128*h - offset
    localparam int NUM_W   = ((MED_W + MED_SHIFT + 1 > OFFSET_W) ?
                              MED_W + MED_SHIFT + 1 : OFFSET_W) + 1;
    localparam int NMAG_W  = NUM_W - 1;
    localparam int OVF_SHIFT = QUOT_W - FRAC_SHIFT;
    localparam int GSH_W   = GAIN_W + OVF_SHIFT;
    localparam int ALU_W   = ((NUM_W > GSH_W) ? NUM_W : GSH_W) + 1;
    localparam int STEP_W  = $clog2(QUOT_W);

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  K_LO      = CNT_W'((WINDOW - 1) / 2);
    localparam logic [CNT_W-1:0]  K_HI      = CNT_W'(WINDOW / 2);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MED   = 10'b0000000010,
        S_DRAIN = 10'b0000000100,
        S_NUM   = 10'b0000001000,
        S_NMAG  = 10'b0000010000,
        S_GMAG  = 10'b0000100000,
        S_OVF   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_SIGN  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    // Control state
    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           widx_reg, widx_next;
    logic [WINDOW-1:0]          valid_reg, valid_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    // Calibration registers
    logic signed [GAIN_W-1:0]   gain_on_reg, gain_on_next;
    logic signed [OFFSET_W-1:0] offset_on_reg, offset_on_next;
    logic signed [GAIN_W-1:0]   gain_off_reg, gain_off_next;
    logic signed [OFFSET_W-1:0] offset_off_reg, offset_off_next;

    // Working registers
    logic                       pump_reg, pump_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic                       cmp_last_reg, cmp_last_next;
    logic                       ok_a_reg, ok_a_next;
    logic                       ok_b_reg, ok_b_next;
    logic [CNT_W-1:0]           lt_cnt_reg, lt_cnt_next;
    logic [CNT_W-1:0]           le_cnt_reg, le_cnt_next;
    logic [SAMPLE_BITS-1:0]     lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0]     hi_reg, hi_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic                       num_neg_reg, num_neg_next;
    logic [NMAG_W-1:0]          nmag_reg, nmag_next;
    logic [GAIN_W-1:0]          gmag_reg, gmag_next;
    logic                       gain_neg_reg, gain_neg_next;
    logic [GAIN_W-1:0]          rem_reg, rem_next;
    logic [QUOT_W-1:0]          dvd_reg, dvd_next;
    logic [QUOT_W-1:0]          quo_reg, quo_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [TEMP_W-1:0]          temp_reg, temp_next;
    logic                       sat_reg, sat_next;
    logic                       zg_reg, zg_next;
    logic [OUT_W-1:0]           m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0]      m_tuser_reg, m_tuser_next;

    // Combinational
    logic                       in_xfer;
    logic [IDX_W-1:0]           widx_wrap;
    logic [SAMPLE_BITS-1:0]     rd_a, rd_b, va, vb;
    logic [MED_W-1:0]           med_half;
    logic signed [GAIN_W-1:0]   gain_sel;
    logic signed [OFFSET_W-1:0] offset_sel;
    logic signed [ALU_W-1:0]    alu_a, alu_b, alu_diff;
    logic                       alu_neg, alu_zero;
    logic [CNT_W-1:0]           lt_tot, le_tot;
    logic [QUOT_W-1:0]          trial;
    logic                       res_neg, pos_ovf, neg_ovf;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign widx_wrap = (widx_reg == IDX_LAST) ? '0 : widx_reg + IDX_W'(1);

    // Window store: write on the input transfer, read candidate and comparand
    mfsc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .we      (in_xfer),
        .waddr   (widx_wrap),
        .wdata   (s_tdata[SAMPLE_BITS-1:0]),
        .raddr_a (i_reg),
        .rdata_a (rd_a),
        .raddr_b (j_reg),
        .rdata_b (rd_b)
    );

    // Entries never written read as zero
    assign va = ok_a_reg ? rd_a : '0;
    assign vb = ok_b_reg ? rd_b : '0;

    assign med_half   = MED_W'(lo_reg) + MED_W'(hi_reg);
    assign gain_sel   = pump_reg ? gain_on_reg : gain_off_reg;
    assign offset_sel = pump_reg ? offset_on_reg : offset_off_reg;
    assign trial      = {rem_reg, dvd_reg[QUOT_W-1]};
    assign res_neg    = num_neg_reg ^ gain_neg_reg;
    assign pos_ovf    = |quo_reg[QUOT_W-1:TEMP_W-1];
    assign neg_ovf    = quo_reg[QUOT_W-1] | (quo_reg[TEMP_W-1] & (|quo_reg[TEMP_W-2:0]));

    // Shared subtractor: operand selection per sequencer step
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            S_MED, S_DRAIN:
            begin
                alu_a = ALU_W'(vb);
                alu_b = ALU_W'(va);
            end
            S_NUM:
            begin
                alu_a = ALU_W'({med_half, {MED_SHIFT{1'b0}}});
                alu_b = ALU_W'(offset_sel);
            end
            S_NMAG:
            begin
                alu_b = ALU_W'(num_reg);
            end
            S_GMAG:
            begin
                alu_b = ALU_W'(gain_sel);
            end
            S_OVF:
            begin
                alu_a = ALU_W'(nmag_reg);
                alu_b = ALU_W'({gmag_reg, {OVF_SHIFT{1'b0}}});
            end
            S_DIV:
            begin
                alu_a = ALU_W'(trial);
                alu_b = ALU_W'(gmag_reg);
            end
            S_SIGN:
            begin
                alu_b = ALU_W'(quo_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff = alu_a - alu_b;
    assign alu_neg  = alu_diff[ALU_W-1];
    assign alu_zero = (alu_diff == '0);

    assign lt_tot = lt_cnt_reg + CNT_W'(alu_neg);
    assign le_tot = le_cnt_reg + CNT_W'(alu_neg | alu_zero);

    // Sequencer and next values
    always_comb
    begin
        state_next      = state_reg;
        widx_next       = widx_reg;
        valid_next      = valid_reg;
        cmp_vld_next    = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        gain_on_next    = gain_on_reg;
        offset_on_next  = offset_on_reg;
        gain_off_next   = gain_off_reg;
        offset_off_next = offset_off_reg;
        pump_next       = pump_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cmp_last_next   = cmp_last_reg;
        ok_a_next       = valid_reg[i_reg];
        ok_b_next       = valid_reg[j_reg];
        lt_cnt_next     = lt_cnt_reg;
        le_cnt_next     = le_cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        num_next        = num_reg;
        num_neg_next    = num_neg_reg;
        nmag_next       = nmag_reg;
        gmag_next       = gmag_reg;
        gain_neg_next   = gain_neg_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        temp_next       = temp_reg;
        sat_next        = sat_reg;
        zg_next         = zg_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        // Drop the result once the downstream side takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_ON:    gain_on_next    = cfg_data[GAIN_W-1:0];
                REG_OFFSET_ON:  offset_on_next  = cfg_data[OFFSET_W-1:0];
                REG_GAIN_OFF:   gain_off_next   = cfg_data[GAIN_W-1:0];
                REG_OFFSET_OFF: offset_off_next = cfg_data[OFFSET_W-1:0];
                default:        gain_on_next    = gain_on_reg;
            endcase
        end

        // Rank the candidate: count entries below it and not above it
        if (cmp_vld_reg)
        begin
            if (cmp_last_reg)
            begin
                if ((lt_tot <= K_LO) && (K_LO < le_tot))
                begin
                    lo_next = va;
                end
                if ((lt_tot <= K_HI) && (K_HI < le_tot))
                begin
                    hi_next = va;
                end
                lt_cnt_next = '0;
                le_cnt_next = '0;
            end
            else
            begin
                lt_cnt_next = lt_tot;
                le_cnt_next = le_tot;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    widx_next             = widx_wrap;
                    valid_next[widx_wrap] = 1'b1;
                    pump_next             = s_tuser;
                    i_next                = '0;
                    j_next                = '0;
                    lt_cnt_next           = '0;
                    le_cnt_next           = '0;
                    sat_next              = 1'b0;
                    zg_next               = 1'b0;
                    state_next            = S_MED;
                end
            end
            S_MED:
            begin
                // Issue one read pair a cycle; compare lands in the cycle after
                cmp_vld_next  = 1'b1;
                cmp_last_next = (j_reg == IDX_LAST);
                if (j_reg == IDX_LAST)
                begin
                    j_next = '0;
                    if (i_reg == IDX_LAST)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_NUM;
            end
            S_NUM:
            begin
                num_next   = alu_diff[NUM_W-1:0];
                state_next = S_NMAG;
            end
            S_NMAG:
            begin
                num_neg_next = num_reg[NUM_W-1];
                nmag_next    = num_reg[NUM_W-1] ? alu_diff[NMAG_W-1:0] : num_reg[NMAG_W-1:0];
                state_next   = S_GMAG;
            end
            S_GMAG:
            begin
                gain_neg_next = gain_sel[GAIN_W-1];
                gmag_next     = gain_sel[GAIN_W-1] ? alu_diff[GAIN_W-1:0] : gain_sel;
                if (gain_sel == '0)
                begin
                    zg_next    = 1'b1;
                    sat_next   = 1'b1;
                    temp_next  = num_neg_reg ? TEMP_MIN : TEMP_MAX;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_OVF;
                end
            end
            S_OVF:
            begin
                // Quotient of 2^17 or more cannot fit: clamp without dividing
                if (!alu_neg)
                begin
                    sat_next   = 1'b1;
                    temp_next  = res_neg ? TEMP_MIN : TEMP_MAX;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next   = GAIN_W'(nmag_reg >> OVF_SHIFT);
                    dvd_next   = {nmag_reg[OVF_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                rem_next  = alu_neg ? trial[GAIN_W-1:0] : alu_diff[GAIN_W-1:0];
                quo_next  = {quo_reg[QUOT_W-2:0], ~alu_neg};
                dvd_next  = {dvd_reg[QUOT_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (res_neg)
                begin
                    sat_next  = neg_ovf;
                    temp_next = neg_ovf ? TEMP_MIN : alu_diff[TEMP_W-1:0];
                end
                else
                begin
                    sat_next  = pos_ovf;
                    temp_next = pos_ovf ? TEMP_MAX : quo_reg[TEMP_W-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next        = 1'b1;
                    m_tdata_next         = OUT_W'({med_half, temp_reg});
                    m_tuser_next         = '0;
                    m_tuser_next[SAT_BIT] = sat_reg;
                    m_tuser_next[ZG_BIT]  = zg_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            widx_reg       <= '0;
            valid_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            gain_on_reg    <= GAIN_W'(256);
            offset_on_reg  <= '0;
            gain_off_reg   <= GAIN_W'(256);
            offset_off_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            widx_reg       <= widx_next;
            valid_reg      <= valid_next;
            cmp_vld_reg    <= cmp_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
            gain_on_reg    <= gain_on_next;
            offset_on_reg  <= offset_on_next;
            gain_off_reg   <= gain_off_next;
            offset_off_reg <= offset_off_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pump_reg     <= pump_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cmp_last_reg <= cmp_last_next;
        ok_a_reg     <= ok_a_next;
        ok_b_reg     <= ok_b_next;
        lt_cnt_reg   <= lt_cnt_next;
        le_cnt_reg   <= le_cnt_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        num_reg      <= num_next;
        num_neg_reg  <= num_neg_next;
        nmag_reg     <= nmag_next;
        gmag_reg     <= gmag_next;
        gain_neg_reg <= gain_neg_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        temp_reg     <= temp_next;
        sat_reg      <= sat_next;
        zg_reg       <= zg_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/mfsc_checker.sv
// Port-level checks for the median-filtered sensor calibration block.
// Depends on mfsc_pkg; bound to the top level at the end of this file.
module mfsc_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input logic                                                   clk,
    input logic                                                   rst_n,
    input logic                                                   s_tvalid,
    input logic                                                   s_tready,
    input logic                                                   m_tvalid,
    input logic                                                   m_tready,
    input logic [((mfsc_pkg::TEMP_W+SAMPLE_BITS+8)/8)*8-1:0]       m_tdata,
    input logic [mfsc_pkg::OUT_USER_W-1:0]                        m_tuser
);

    import mfsc_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item at a time: no second transfer straight after the first
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while busy");

    // Zero gain always reports saturation
    a_zg_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[ZG_BIT] |-> m_tuser[SAT_BIT])
        else $error("zero gain without saturation");

    // A clamped temperature sits at one of the rails
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[SAT_BIT] |->
            (m_tdata[TEMP_W-1:0] == TEMP_MAX) || (m_tdata[TEMP_W-1:0] == TEMP_MIN))
        else $error("saturated temperature off the rails");

endmodule

bind median_filtered_sensor_calibration mfsc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mfsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
